>>> rtl/lms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift motor sequencer package
// Shared types, register indexes, reset values and command codes.
// ----------------------------------------------------------------------------
package lms_pkg;

   // Width of the torque path unless the top level is given another value.
   localparam int TORQUE_BITS_DEFAULT = 16;

   // Field widths of the word formats.
   localparam int ACTION_W  = 2;
   localparam int HOLD_W    = 22;
   localparam int TIME_W    = 32;
   localparam int TORQUE_W  = 16;
   localparam int CMD_W     = 3;
   localparam int PHASE_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int COUNT_W   = 6;

   // Milliseconds to microseconds.
   localparam logic [TIME_W-1:0] MS_TO_US = 32'd1000;

   // Starting value of the baseline minimum before saturation to the torque width.
   localparam longint unsigned MIN_TORQUE_START = 64'd1000;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RONDELL_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAVEL_TIME    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_THRESHOLD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_CONFIRM    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTACT_DROP   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_TIME   = 3'd6;

   // Register reset values.
   localparam logic                 RST_RONDELL_MODE   = 1'b0;
   localparam logic [15:0]          RST_TRAVEL_TIME    = 16'd1000;
   localparam logic [15:0]          RST_TOP_THRESHOLD  = 16'd5;
   localparam logic [COUNT_W-1:0]   RST_TOP_CONFIRM    = 6'd8;
   localparam logic [COUNT_W-1:0]   RST_BASELINE_COUNT = 6'd50;
   localparam logic [15:0]          RST_CONTACT_DROP   = 16'd10;
   localparam logic [15:0]          RST_BACKOFF_TIME   = 16'd100;

   // Actions carried by an input word.
   localparam logic [ACTION_W-1:0] ACT_STEP = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_HOLD = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STOP = 2'd2;

   // Motor commands.
   localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_STOP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UP_FAST = 3'd2;
   localparam logic [CMD_W-1:0] CMD_UP_SLOW = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DOWN    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_REINIT  = 3'd5;

   typedef struct packed {
      logic                rondell_mode;
      logic [15:0]         travel_time_ms;
      logic [15:0]         top_torque_threshold;
      logic [COUNT_W-1:0]  top_confirm_count;
      logic [COUNT_W-1:0]  baseline_samples;
      logic [15:0]         contact_drop;
      logic [15:0]         backoff_ms;
   } cfg_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [HOLD_W-1:0]   hold_ms;
      logic [TIME_W-1:0]   now_us;
      logic [TORQUE_W-1:0] torque;
      logic                limit_closed;
      logic                motor_ok;
   } item_type;

   typedef struct packed {
      logic [CMD_W-1:0]   motor_command;
      logic [PHASE_W-1:0] phase_code;
   } result_type;

endpackage

>>> rtl/lift_motor_sequencer.sv
`timescale 1ns / 1ps
// Each request word is registered in the input register and its result word in the result register.
// Throughput: one word per cycle while the receiving side does not stall; the step logic
// sits between the input register and the result register and finishes each word in one pass.
// Reset (synchronous, active high): empty pipeline, sleep phase, cleared
// deadlines and counters, baseline minimum at its start value, default settings.
// ----------------------------------------------------------------------------
// Lift motor sequencer
// Six-phase lift controller: one motor command and phase code per word.
// ----------------------------------------------------------------------------
module lift_motor_sequencer #(
   parameter int TORQUE_BITS = lms_pkg::TORQUE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [lms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lms_pkg::CSR_DAT_W-1:0]    csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [lms_pkg::ACTION_W-1:0]     req_action,
   input  logic [lms_pkg::HOLD_W-1:0]       req_hold_ms,
   input  logic [lms_pkg::TIME_W-1:0]       req_now_us,
   input  logic [lms_pkg::TORQUE_W-1:0]     req_torque,
   input  logic                             req_limit_closed,
   input  logic                             req_motor_ok,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [lms_pkg::CMD_W-1:0]        rsp_motor_command,
   output logic [lms_pkg::PHASE_W-1:0]      rsp_phase_code
);
   import lms_pkg::*;

   cfg_type    cfg;
   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   logic       fire;
   result_type result;
   result_type rsp_result;

   assign req_item.action       = req_action;
   assign req_item.hold_ms      = req_hold_ms;
   assign req_item.now_us       = req_now_us;
   assign req_item.torque       = req_torque;
   assign req_item.limit_closed = req_limit_closed;
   assign req_item.motor_ok     = req_motor_ok;

   // A word is processed when it is present and the result register can take it.
   assign fire = item_valid & advance;

   lms_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lms_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   lms_step #(
      .TORQUE_BITS (TORQUE_BITS)
   ) u_step (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (item),
      .fire   (fire),
      .result (result)
   );

   lms_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_motor_command = rsp_result.motor_command;
   assign rsp_phase_code    = rsp_result.phase_code;

endmodule

>>> rtl/lms_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift motor sequencer configuration registers
// Holds the seven settings written through the plain write port.
// ----------------------------------------------------------------------------
module lms_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [lms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lms_pkg::CSR_DAT_W-1:0]    csr_write_data,
   output lms_pkg::cfg_type                 cfg
);
   import lms_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Decode the index; writes beyond the register list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RONDELL_MODE:   cfg_in.rondell_mode         = csr_write_data[0];
            CSR_TRAVEL_TIME:    cfg_in.travel_time_ms       = csr_write_data;
            CSR_TOP_THRESHOLD:  cfg_in.top_torque_threshold = csr_write_data;
            CSR_TOP_CONFIRM:    cfg_in.top_confirm_count    = csr_write_data[COUNT_W-1:0];
            CSR_BASELINE_COUNT: cfg_in.baseline_samples     = csr_write_data[COUNT_W-1:0];
            CSR_CONTACT_DROP:   cfg_in.contact_drop         = csr_write_data;
            CSR_BACKOFF_TIME:   cfg_in.backoff_ms           = csr_write_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rondell_mode         <= RST_RONDELL_MODE;
         cfg_ff.travel_time_ms       <= RST_TRAVEL_TIME;
         cfg_ff.top_torque_threshold <= RST_TOP_THRESHOLD;
         cfg_ff.top_confirm_count    <= RST_TOP_CONFIRM;
         cfg_ff.baseline_samples     <= RST_BASELINE_COUNT;
         cfg_ff.contact_drop         <= RST_CONTACT_DROP;
         cfg_ff.backoff_ms           <= RST_BACKOFF_TIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/lms_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift motor sequencer input register
// Captures one request word and holds it until the step logic takes it.
// ----------------------------------------------------------------------------
module lms_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lms_pkg::item_type  req_item,
   input  logic               advance,
   output logic               item_valid,
   output lms_pkg::item_type  item
);
   import lms_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take;

   // The slot is free when empty or when its word moves on this cycle.
   assign req_stall = valid_ff & ~advance;
   assign take      = req_valid & ~req_stall;
   assign valid_in  = take | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/lms_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift motor sequencer step logic
// Phase state, deadlines and torque tracking, updated once per word.
// ----------------------------------------------------------------------------
module lms_step #(
   parameter int TORQUE_BITS = lms_pkg::TORQUE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lms_pkg::cfg_type     cfg,
   input  lms_pkg::item_type    item,
   input  logic                 fire,
   output lms_pkg::result_type  result
);
   import lms_pkg::*;

   localparam longint unsigned TMASK     = (64'd1 << TORQUE_BITS) - 64'd1;
   localparam longint unsigned MIN_START =
      (MIN_TORQUE_START > TMASK) ? TMASK : MIN_TORQUE_START;
   localparam logic [TORQUE_BITS-1:0] MIN_RESET = MIN_START[TORQUE_BITS-1:0];

   typedef enum logic [PHASE_W-1:0] {
      PH_SLEEP   = 3'd0,
      PH_UP      = 3'd1,
      PH_TOP     = 3'd2,
      PH_DOWN    = 3'd3,
      PH_CONTACT = 3'd4,
      PH_ERROR   = 3'd5
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [HOLD_W-1:0]       hold_time_ff, hold_time_in;
   logic [TIME_W-1:0]       travel_deadline_ff, travel_deadline_in;
   logic [TIME_W-1:0]       top_deadline_ff, top_deadline_in;
   logic [COUNT_W-1:0]      sample_count_ff, sample_count_in;
   logic [TORQUE_BITS-1:0]  minimum_torque_ff, minimum_torque_in;
   logic                    contact_seen_ff, contact_seen_in;
   logic                    backing_off_ff, backing_off_in;
   logic [CMD_W-1:0]        cmd;

   // Torque is taken at the configured width; the top threshold compare is done at 32 bits.
   logic [TIME_W-1:0]       torque_wide;
   logic [TORQUE_BITS-1:0]  torque;
   logic [TIME_W-1:0]       torque_cmp;
   logic [TORQUE_BITS-1:0]  contact_bound;
   logic [TIME_W-1:0]       travel_due;
   logic [TIME_W-1:0]       backoff_due;
   logic [TIME_W-1:0]       hold_due;

   assign torque_wide   = TIME_W'(item.torque);
   assign torque        = torque_wide[TORQUE_BITS-1:0];
   assign torque_cmp    = TIME_W'(torque);
   assign contact_bound = TORQUE_BITS'(TIME_W'(minimum_torque_ff) - TIME_W'(cfg.contact_drop));

   // Deadlines are the current time plus a millisecond count, wrapping at 32 bits.
   assign travel_due  = item.now_us + TIME_W'(TIME_W'(cfg.travel_time_ms) * MS_TO_US);
   assign backoff_due = item.now_us + TIME_W'(TIME_W'(cfg.backoff_ms) * MS_TO_US);
   assign hold_due    = item.now_us + TIME_W'(TIME_W'(hold_time_ff) * MS_TO_US);

   // Next state and command for the word in the input register.
   always_comb begin
      phase_type         ph;
      logic [TIME_W-1:0] td;
      ph                 = phase_ff;
      td                 = top_deadline_ff;
      phase_in           = phase_ff;
      hold_time_in       = hold_time_ff;
      travel_deadline_in = travel_deadline_ff;
      top_deadline_in    = top_deadline_ff;
      sample_count_in    = sample_count_ff;
      minimum_torque_in  = minimum_torque_ff;
      contact_seen_in    = contact_seen_ff;
      backing_off_in     = backing_off_ff;
      cmd                = CMD_NONE;

      case (item.action)
         ACT_HOLD: begin
            hold_time_in = item.hold_ms;
         end
         ACT_STOP: begin
            cmd            = CMD_STOP;
            hold_time_in   = '0;
            backing_off_in = 1'b0;
            phase_in       = PH_SLEEP;
         end
         ACT_STEP: begin
            // A lost driver link forces the error phase before anything else.
            if (!item.motor_ok) begin
               ph             = PH_ERROR;
               backing_off_in = 1'b0;
            end
            phase_in = ph;
            case (ph)
               PH_SLEEP: begin
                  if (hold_time_ff != '0) begin
                     if (cfg.rondell_mode) begin
                        travel_deadline_in = travel_due;
                     end
                     cmd      = CMD_UP_FAST;
                     phase_in = PH_UP;
                  end
               end
               PH_UP: begin
                  if (cfg.rondell_mode) begin
                     if (travel_deadline_ff <= item.now_us) begin
                        cmd                = CMD_STOP;
                        travel_deadline_in = '0;
                        phase_in           = PH_TOP;
                     end
                  end else begin
                     // Count a run of low-torque samples to confirm the top.
                     if (torque_cmp < TIME_W'(cfg.top_torque_threshold)) begin
                        sample_count_in = sample_count_ff + COUNT_W'(1);
                     end else begin
                        sample_count_in = '0;
                     end
                     if (sample_count_in == cfg.top_confirm_count) begin
                        cmd             = CMD_STOP;
                        sample_count_in = '0;
                        phase_in        = PH_TOP;
                     end
                  end
               end
               PH_TOP: begin
                  if (hold_time_ff != '0 && td == '0) begin
                     td = hold_due;
                  end
                  top_deadline_in = td;
                  if (td <= item.now_us) begin
                     hold_time_in    = '0;
                     top_deadline_in = '0;
                     cmd             = CMD_DOWN;
                     phase_in        = PH_DOWN;
                  end
               end
               PH_DOWN: begin
                  if (item.limit_closed) begin
                     if (cfg.rondell_mode) begin
                        cmd      = CMD_STOP;
                        phase_in = PH_SLEEP;
                     end else begin
                        minimum_torque_in = MIN_RESET;
                        sample_count_in   = '0;
                        contact_seen_in   = 1'b0;
                        backing_off_in    = 1'b0;
                        cmd               = CMD_UP_SLOW;
                        phase_in          = PH_CONTACT;
                     end
                  end
               end
               PH_CONTACT: begin
                  // Baseline minimum, then the drop test, then a timed back-off.
                  if (sample_count_ff < cfg.baseline_samples) begin
                     if (torque < minimum_torque_ff) begin
                        minimum_torque_in = torque;
                     end
                     sample_count_in = sample_count_ff + COUNT_W'(1);
                  end else if (!contact_seen_ff) begin
                     if (torque < contact_bound) begin
                        contact_seen_in = 1'b1;
                     end
                  end else if (!backing_off_ff) begin
                     travel_deadline_in = backoff_due;
                     backing_off_in     = 1'b1;
                     cmd                = CMD_DOWN;
                  end else if (travel_deadline_ff <= item.now_us) begin
                     travel_deadline_in = '0;
                     backing_off_in     = 1'b0;
                     sample_count_in    = '0;
                     hold_time_in       = '0;
                     cmd                = CMD_STOP;
                     phase_in           = PH_SLEEP;
                  end
               end
               PH_ERROR: begin
                  cmd = CMD_REINIT;
                  if (item.motor_ok) begin
                     hold_time_in = '0;
                     phase_in     = PH_SLEEP;
                  end
               end
               default: begin
                  phase_in = PH_SLEEP;
               end
            endcase
         end
         default: begin
            cmd = CMD_NONE;
         end
      endcase
   end

   // State moves only when a word passes to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_SLEEP;
         hold_time_ff       <= '0;
         travel_deadline_ff <= '0;
         top_deadline_ff    <= '0;
         sample_count_ff    <= '0;
         minimum_torque_ff  <= MIN_RESET;
         contact_seen_ff    <= 1'b0;
         backing_off_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff           <= phase_in;
         hold_time_ff       <= hold_time_in;
         travel_deadline_ff <= travel_deadline_in;
         top_deadline_ff    <= top_deadline_in;
         sample_count_ff    <= sample_count_in;
         minimum_torque_ff  <= minimum_torque_in;
         contact_seen_ff    <= contact_seen_in;
         backing_off_ff     <= backing_off_in;
      end
   end

   assign result.motor_command = cmd;
   assign result.phase_code    = PHASE_W'(phase_in);

endmodule

>>> rtl/lms_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift motor sequencer result register
// Holds one result word until the receiving side takes it.
// ----------------------------------------------------------------------------
module lms_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  lms_pkg::result_type  result,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lms_pkg::result_type  rsp_result
);
   import lms_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   // A new word may enter when the register is empty or is being emptied.
   assign advance  = ~valid_ff | ~rsp_stall;
   assign valid_in = fire | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule
